// ===== rtl/adpcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adpcm_pkg
// Shared types, operation codes and constants of the predictive ADPCM decoder.
// ----------------------------------------------------------------------------
package adpcm_pkg;

	// Number of channels with their own coefficient table and history
	localparam int CHANNELS_DEFAULT = 2;

	// Coefficient table layout: 16 entries per channel, split into 8 pairs
	localparam int COEF_W      = 16;
	localparam int COEF_PAIRS  = 8;
	localparam int PAIR_W      = 3;

	// Prediction scaling
	localparam int PRED_SHIFT  = 11;

	// Frame header keeps bits 6..0: pair index in 6..4, exponent in 3..0
	localparam int HDR_W       = 7;

	// Operation codes
	localparam logic [1:0] OP_LOAD_COEF = 2'd0;
	localparam logic [1:0] OP_LOAD_HIST = 2'd1;
	localparam logic [1:0] OP_HEADER    = 2'd2;
	localparam logic [1:0] OP_SAMPLE    = 2'd3;

	// One input item
	typedef struct packed {
		logic [1:0]         operation;
		logic               channel;
		logic [3:0]         coef_slot;
		logic signed [15:0] value_a;
		logic signed [15:0] value_b;
		logic [7:0]         code;
	} cmd_item_t;

	// One decoded sample
	typedef struct packed {
		logic signed [15:0] sample;
		logic               sample_channel;
	} smp_item_t;

endpackage : adpcm_pkg
`default_nettype wire

// ===== rtl/adpcm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adpcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module adpcm_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output      logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, held while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule : adpcm_ram
`default_nettype wire

// ===== rtl/adpcm_predict.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adpcm_predict
// Two-tap prediction, scaled nibble add and 16-bit saturation.
// ----------------------------------------------------------------------------
module adpcm_predict
	import adpcm_pkg::*;
(
	input  wire logic signed [15:0] hist_new,
	input  wire logic signed [15:0] hist_old,
	input  wire logic signed [15:0] coef_a,
	input  wire logic signed [15:0] coef_b,
	input  wire logic [3:0]         nibble,
	input  wire logic [3:0]         expo,
	output      logic signed [15:0] sample
);

	localparam int PRED_W = 33 - PRED_SHIFT;

	logic signed [31:0]       prod_a;
	logic signed [31:0]       prod_b;
	logic signed [32:0]       pred;
	logic signed [PRED_W-1:0] pred_sh;
	logic [18:0]              nib_ext;
	logic [18:0]              step;
	logic signed [22:0]       sum;
	logic                     ovf;

	// the two taps
	assign prod_a = hist_new * coef_a;
	assign prod_b = hist_old * coef_b;
	assign pred   = {prod_a[31], prod_a} + {prod_b[31], prod_b};

	// dropping the low bits is an arithmetic shift rounding toward minus infinity
	assign pred_sh = pred[32:PRED_SHIFT];

	// sign-extended nibble scaled by the exponent
	assign nib_ext = {{15{nibble[3]}}, nibble};
	assign step    = nib_ext << expo;

	assign sum = {{(23 - PRED_W){pred_sh[PRED_W-1]}}, pred_sh} + {{4{step[18]}}, step};

	// saturate: out of range when bits 22..15 are not all equal
	assign ovf = (sum[22:15] != {8{sum[22]}});

	always_comb begin
		if (!ovf) begin
			sample = sum[15:0];
		end else if (sum[22]) begin
			sample = 16'sh8000;
		end else begin
			sample = 16'sh7FFF;
		end
	end

endmodule : adpcm_predict
`default_nettype wire

// ===== rtl/adpcm_predictive_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adpcm_predictive_decoder_core
// Per-channel two-tap predictive ADPCM decoder with coefficient, history and
// frame header loads.
// ----------------------------------------------------------------------------
//  channel | direction | transfer when          | payload
//  cmd     | into core | cmd_valid && !cmd_stall | cmd_item_t
//  smp     | out       | smp_valid && !smp_stall | smp_item_t
//
//  One item is taken every cycle while cmd_stall is low; a sample's transfer
//  loads the coefficient RAM read and stage one, then the prediction enters the
//  output register. The coefficient RAM read and the history feedback through
//  the prediction path shape this pipeline.
//  Reset clears history and frame headers; coefficients are undefined until
//  loaded. cmd_stall rises only while a decoded sample waits in stage one
//  behind a stalled output register.
// ----------------------------------------------------------------------------
module adpcm_predictive_decoder_core
	import adpcm_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEFAULT
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output      logic      cmd_stall,
	input  wire cmd_item_t cmd,
	output      logic      smp_valid,
	input  wire logic      smp_stall,
	output      smp_item_t smp
);

	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int RAM_D    = CHANNELS * COEF_PAIRS;
	localparam int RAM_AW   = (RAM_D > 1) ? $clog2(RAM_D) : 1;

	logic              accept;
	logic              ch_ok;
	logic [CH_W-1:0]   ch_idx;
	logic [HDR_W-1:0]  cur_hdr;

	logic [HDR_W-1:0]  hdr_q [CHANNELS];
	logic signed [15:0] hist_new_q [CHANNELS];
	logic signed [15:0] hist_old_q [CHANNELS];

	logic              coef_we;
	logic [RAM_AW-1:0] coef_waddr;
	logic [RAM_AW-1:0] coef_raddr;
	logic              coef_re;
	logic [COEF_W-1:0] coef_even;
	logic [COEF_W-1:0] coef_odd;

	logic              valid_s1;
	logic              is_sample_s1;
	logic [CH_W-1:0]   ch_s1;
	logic              chan_s1;
	logic signed [15:0] value_a_s1;
	logic signed [15:0] value_b_s1;
	logic [3:0]        nibble_s1;
	logic [3:0]        expo_s1;
	logic              go_s1;

	logic signed [15:0] dec_sample;
	logic              smp_valid_q;
	smp_item_t         smp_q;

	// input decode
	assign accept  = cmd_valid && !cmd_stall;
	assign ch_ok   = int'(cmd.channel) < CHANNELS;
	assign ch_idx  = CH_W'(cmd.channel);
	assign cur_hdr = hdr_q[ch_idx];

	// stage one moves unless a sample waits on a stalled output register
	assign go_s1     = !valid_s1 || !is_sample_s1 || !smp_valid_q || !smp_stall;
	assign cmd_stall = valid_s1 && !go_s1;

	// coefficient RAMs: even entries and odd entries of each pair
	assign coef_we    = accept && ch_ok && (cmd.operation == OP_LOAD_COEF);
	assign coef_waddr = RAM_AW'({ch_idx, cmd.coef_slot[3:1]});
	assign coef_re    = accept && ch_ok && (cmd.operation == OP_SAMPLE);
	assign coef_raddr = RAM_AW'({ch_idx, cur_hdr[6:4]});

	adpcm_ram #(
		.WIDTH (COEF_W),
		.DEPTH (RAM_D)
	) u_coef_even (
		.clk     (clk),
		.wr_en   (coef_we && !cmd.coef_slot[0]),
		.wr_addr (coef_waddr),
		.wr_data (cmd.value_a),
		.rd_en   (coef_re),
		.rd_addr (coef_raddr),
		.rd_data (coef_even)
	);

	adpcm_ram #(
		.WIDTH (COEF_W),
		.DEPTH (RAM_D)
	) u_coef_odd (
		.clk     (clk),
		.wr_en   (coef_we && cmd.coef_slot[0]),
		.wr_addr (coef_waddr),
		.wr_data (cmd.value_a),
		.rd_en   (coef_re),
		.rd_addr (coef_raddr),
		.rd_data (coef_odd)
	);

	// frame headers update on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				hdr_q[i] <= '0;
			end
		end else if (accept && ch_ok && (cmd.operation == OP_HEADER)) begin
			hdr_q[ch_idx] <= cmd.code[HDR_W-1:0];
		end
	end

	// stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (go_s1) begin
			valid_s1 <= accept && ch_ok &&
				((cmd.operation == OP_LOAD_HIST) || (cmd.operation == OP_SAMPLE));
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (go_s1 && accept) begin
			is_sample_s1 <= (cmd.operation == OP_SAMPLE);
			ch_s1        <= ch_idx;
			chan_s1      <= cmd.channel;
			value_a_s1   <= cmd.value_a;
			value_b_s1   <= cmd.value_b;
			nibble_s1    <= cmd.code[3:0];
			expo_s1      <= cur_hdr[3:0];
		end
	end

	adpcm_predict u_predict (
		.hist_new (hist_new_q[ch_s1]),
		.hist_old (hist_old_q[ch_s1]),
		.coef_a   (coef_even),
		.coef_b   (coef_odd),
		.nibble   (nibble_s1),
		.expo     (expo_s1),
		.sample   (dec_sample)
	);

	// history: loads and decoded samples applied in order as stage one leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				hist_new_q[i] <= '0;
				hist_old_q[i] <= '0;
			end
		end else if (valid_s1 && go_s1) begin
			if (is_sample_s1) begin
				hist_new_q[ch_s1] <= dec_sample;
				hist_old_q[ch_s1] <= hist_new_q[ch_s1];
			end else begin
				hist_new_q[ch_s1] <= value_a_s1;
				hist_old_q[ch_s1] <= value_b_s1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_valid_q <= 1'b0;
		end else if (valid_s1 && is_sample_s1 && go_s1) begin
			smp_valid_q <= 1'b1;
		end else if (!smp_stall) begin
			smp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && is_sample_s1 && go_s1) begin
			smp_q.sample         <= dec_sample;
			smp_q.sample_channel <= chan_s1;
		end
	end

	assign smp_valid = smp_valid_q;
	assign smp       = smp_q;

endmodule : adpcm_predictive_decoder_core
`default_nettype wire
